### rtl/core/fape_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_pkg
// Shared types and constants of the flag ALU execute block: opcodes, halt
// codes, flag positions, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package fape_pkg;

  // Fixed data and field sizes.
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned ByteValues = 256;
  localparam int unsigned InsnBytes  = 4;

  // Opcodes.
  localparam logic [7:0] OpEnd      = 8'd0;
  localparam logic [7:0] OpAdd      = 8'd1;
  localparam logic [7:0] OpSub      = 8'd2;
  localparam logic [7:0] OpMul      = 8'd3;
  localparam logic [7:0] OpDiv      = 8'd4;
  localparam logic [7:0] OpLoadReg  = 8'd5;
  localparam logic [7:0] OpStoreReg = 8'd6;
  localparam logic [7:0] OpMovZ     = 8'd7;
  localparam logic [7:0] OpNot      = 8'd8;
  localparam logic [7:0] OpAddI     = 8'd9;
  localparam logic [7:0] OpSubI     = 8'd10;
  localparam logic [7:0] OpMulI     = 8'd11;
  localparam logic [7:0] OpDivI     = 8'd12;
  localparam logic [7:0] OpLoadAbs  = 8'd13;
  localparam logic [7:0] OpStoreAbs = 8'd14;
  localparam logic [7:0] OpMovS     = 8'd15;
  localparam logic [7:0] OpBrZ      = 8'd16;
  localparam logic [7:0] OpBrNz     = 8'd17;
  localparam logic [7:0] OpBrC      = 8'd18;
  localparam logic [7:0] OpBrNc     = 8'd19;
  localparam logic [7:0] OpBrN      = 8'd20;
  localparam logic [7:0] OpBrNn     = 8'd21;
  localparam logic [7:0] OpBrV      = 8'd22;
  localparam logic [7:0] OpBrNv     = 8'd23;
  localparam logic [7:0] OpBrHi     = 8'd24;
  localparam logic [7:0] OpBrLs     = 8'd25;
  localparam logic [7:0] OpBrGe     = 8'd26;
  localparam logic [7:0] OpBrLt     = 8'd27;
  localparam logic [7:0] OpBrGt     = 8'd28;
  localparam logic [7:0] OpBrLe     = 8'd29;
  localparam logic [7:0] OpBrAl     = 8'd30;

  // Halt status codes.
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatEnd     = 2'd1;
  localparam logic [1:0] StatDivZero = 2'd2;
  localparam logic [1:0] StatInvalid = 2'd3;

  // Flag bit positions.
  localparam int unsigned FlagZ = 0;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 2;
  localparam int unsigned FlagV = 3;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StExec,
    StDiv,
    StLoad,
    StFinish
  } fape_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic div_start;
    logic mem_rd;
    logic commit;
  } fape_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic need_load;
    logic div_busy;
    logic out_free;
  } fape_sts_t;

  // Result payload.
  typedef struct packed {
    logic [15:0]       next_pc;
    logic              halted;
    logic [1:0]        status;
    logic              zero_flag;
    logic              negative_flag;
    logic              carry_flag;
    logic              overflow_flag;
    logic              reg_written;
    logic [7:0]        written_index;
    logic signed [31:0] written_value;
  } fape_res_t;

endpackage

### rtl/core/fape_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_inst_if / fape_res_if
// Valid/ready channels for instructions in and execution results out.
// ----------------------------------------------------------------------------
interface fape_inst_if;
  logic       valid;
  logic       ready;
  logic [7:0] action;
  logic [7:0] dest_field;
  logic [7:0] src_a_field;
  logic [7:0] src_b_field;

  modport source (output valid, action, dest_field, src_a_field, src_b_field, input ready);
  modport sink   (input valid, action, dest_field, src_a_field, src_b_field, output ready);
endinterface

interface fape_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic               halted;
  logic [1:0]         status;
  logic               zero_flag;
  logic               negative_flag;
  logic               carry_flag;
  logic               overflow_flag;
  logic               reg_written;
  logic [7:0]         written_index;
  logic signed [31:0] written_value;

  modport source (output valid, next_pc, halted, status, zero_flag, negative_flag,
                  carry_flag, overflow_flag, reg_written, written_index, written_value,
                  input ready);
  modport sink   (input valid, next_pc, halted, status, zero_flag, negative_flag,
                  carry_flag, overflow_flag, reg_written, written_index, written_value,
                  output ready);
endinterface

### rtl/core/fape_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fape_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/fape_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fape_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import fape_pkg::*;

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] shifted, trial;

  // One trial subtraction per step.
  assign shifted = {rem_q, quo_q[DataWidth-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  // Control state of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(DataWidth - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[DataWidth]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/fape_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_datapath
// Register file, data memory, ALU, divider, flags, PC and result register.
// ----------------------------------------------------------------------------
module fape_datapath #(
  parameter int unsigned REGISTER_COUNT = 256,
  parameter int unsigned DATA_WORDS     = 256,
  parameter int unsigned PC_WIDTH       = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fape_pkg::fape_cmd_t cmd_i,
  output fape_pkg::fape_sts_t sts_o,
  input  logic [7:0]          action_i,
  input  logic [7:0]          dest_field_i,
  input  logic [7:0]          src_a_field_i,
  input  logic [7:0]          src_b_field_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output fape_pkg::fape_res_t res_o
);
  import fape_pkg::*;

  localparam int unsigned RegAw    = $clog2(REGISTER_COUNT);
  localparam int unsigned DataAw   = $clog2(DATA_WORDS);
  localparam int unsigned MaxDepth = (REGISTER_COUNT > DATA_WORDS) ? REGISTER_COUNT : DATA_WORDS;
  localparam int unsigned ClrW     = $clog2(MaxDepth);
  localparam bit          DataPow2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);
  // Reciprocal of the data depth, scaled so the quotient estimate is short by at most one.
  localparam int unsigned ModShift = 32 + DataAw;
  localparam logic [32:0] ModRecip = 33'((65'd1 << ModShift) / DATA_WORDS);

  // Byte-to-index reduction tables.
  logic [RegAw-1:0]  rmod_tbl [ByteValues];
  logic [DataAw-1:0] dmod_tbl [ByteValues];
  for (genvar gi = 0; gi < ByteValues; gi++) begin : g_tbl
    assign rmod_tbl[gi] = RegAw'(gi % REGISTER_COUNT);
    assign dmod_tbl[gi] = DataAw'(gi % DATA_WORDS);
  end

  // Captured instruction and architectural state.
  logic [7:0]          act_q, d_q, s1_q, s2_q;
  logic [PC_WIDTH-1:0] pc_q, pc_d;
  logic [3:0]          flags_q, flags_d;
  logic                stop_q;
  logic [1:0]          code_q, code_d;
  logic                halt_d;
  logic                div_neg_q;
  logic [ClrW-1:0]     clr_cnt_q;
  logic                out_valid_q;
  fape_res_t           out_q;

  // Memory ports.
  logic [RegAw-1:0]  rf_raddr_a, rf_raddr_b, rf_waddr, widx;
  logic              rf_we;
  logic [31:0]       rf_wdata, opa, opb;
  logic [DataAw-1:0] dm_addr, dm_waddr, reg_maddr;
  logic              dm_we;
  logic [31:0]       dm_wdata, dm_rdata;

  // Operands and results.
  logic [31:0] imm_b, imm_a, opnd2, dvs, reg_addr_val, res, quo;
  logic [31:0] div_dividend, div_divisor, div_res, prod, diff;
  logic [32:0] sum;
  logic        div_busy, div_zero, is_div, is_load, is_store, is_br, wr;
  logic        need_div, take;
  logic [PC_WIDTH-1:0] pc_inc, pc_br;

  // Address reduction for a data depth that is not a power of two.
  logic        mod_start, mod_busy_q;
  logic [64:0] mod_prod;
  logic [31:0] mod_x_q, mod_q_q, mod_r_q, mod_fix;

  // Branch condition on the current flags.
  function automatic logic cond_holds(input logic [7:0] op, input logic [3:0] f);
    logic z, n, c, v, r;
    z = f[FlagZ];
    n = f[FlagN];
    c = f[FlagC];
    v = f[FlagV];
    case (op)
      OpBrZ:   r = z;
      OpBrNz:  r = !z;
      OpBrC:   r = c;
      OpBrNc:  r = !c;
      OpBrN:   r = n;
      OpBrNn:  r = !n;
      OpBrV:   r = v;
      OpBrNv:  r = !v;
      OpBrHi:  r = c && !z;
      OpBrLs:  r = !c || z;
      OpBrGe:  r = (n == v);
      OpBrLt:  r = (n != v);
      OpBrGt:  r = !z && (n == v);
      OpBrLe:  r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // Capture the instruction at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      d_q   <= dest_field_i;
      s1_q  <= src_a_field_i;
      s2_q  <= src_b_field_i;
    end
  end

  // Register file: two copies give two read ports.
  assign rf_raddr_a = rmod_tbl[(action_i == OpStoreReg) ? dest_field_i : src_a_field_i];
  assign rf_raddr_b = rmod_tbl[src_b_field_i];
  assign widx       = rmod_tbl[d_q];
  assign rf_we      = cmd_i.clear || (cmd_i.commit && wr && !stop_q);
  assign rf_waddr   = cmd_i.clear ? clr_cnt_q[RegAw-1:0] : widx;
  assign rf_wdata   = cmd_i.clear ? '0 : res;

  fape_ram #(.WIDTH(DataWidth), .DEPTH(REGISTER_COUNT)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .re_i(cmd_i.capture), .raddr_i(rf_raddr_a), .rdata_o(opa)
  );
  fape_ram #(.WIDTH(DataWidth), .DEPTH(REGISTER_COUNT)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .re_i(cmd_i.capture), .raddr_i(rf_raddr_b), .rdata_o(opb)
  );

  // Operand selection.
  assign imm_b   = {{24{s2_q[7]}}, s2_q};
  assign imm_a   = {{24{s1_q[7]}}, s1_q};
  assign opnd2   = (act_q inside {OpAddI, OpSubI, OpMulI}) ? imm_b : opb;
  assign dvs     = (act_q == OpDivI) ? imm_b : opb;
  assign sum     = {1'b0, opa} + {1'b0, opnd2};
  assign diff    = opa - opnd2;
  assign prod    = opa * opnd2;
  assign is_div  = act_q inside {OpDiv, OpDivI};
  assign is_load = act_q inside {OpLoadReg, OpLoadAbs};
  assign is_store = act_q inside {OpStoreReg, OpStoreAbs};
  assign is_br   = (act_q >= OpBrZ) && (act_q <= OpBrAl);
  assign div_zero = (dvs == '0);

  // Signed division on magnitudes; the sign is applied afterwards.
  assign reg_addr_val = (act_q == OpStoreReg) ? opa : opb;
  assign div_dividend = opa[31] ? (32'd0 - opa) : opa;
  assign div_divisor  = dvs[31] ? (32'd0 - dvs) : dvs;

  fape_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start && is_div), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .busy_o(div_busy), .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_neg_q <= opa[31] ^ dvs[31];
    end
  end
  assign div_res = div_neg_q ? (32'd0 - quo) : quo;

  // Address modulo the data depth: quotient estimate, then remainder, then
  // one conditional subtraction.
  assign mod_start = cmd_i.div_start && !is_div;
  assign mod_prod  = {33'd0, reg_addr_val} * {32'd0, ModRecip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_busy_q <= 1'b0;
    end else begin
      mod_busy_q <= mod_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mod_start) begin
      mod_x_q <= reg_addr_val;
      mod_q_q <= 32'(mod_prod >> ModShift);
    end
    if (mod_busy_q) begin
      mod_r_q <= mod_x_q - mod_q_q * DataWidth'(DATA_WORDS);
    end
  end

  assign mod_fix = (mod_r_q >= DataWidth'(DATA_WORDS)) ?
                   (mod_r_q - DataWidth'(DATA_WORDS)) : mod_r_q;

  // Data memory address and port.
  assign reg_maddr = DataPow2 ? reg_addr_val[DataAw-1:0] : mod_fix[DataAw-1:0];
  assign dm_addr   = (act_q inside {OpLoadAbs, OpStoreAbs}) ? dmod_tbl[s2_q] : reg_maddr;
  assign dm_we     = cmd_i.clear || (cmd_i.commit && !stop_q && is_store);
  assign dm_waddr  = cmd_i.clear ? clr_cnt_q[DataAw-1:0] : dm_addr;
  assign dm_wdata  = cmd_i.clear ? '0 : ((act_q == OpStoreReg) ? opb : opa);

  fape_ram #(.WIDTH(DataWidth), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .re_i(cmd_i.mem_rd), .raddr_i(dm_addr), .rdata_o(dm_rdata)
  );

  // Result, flags and halt decode.
  always_comb begin
    res     = '0;
    wr      = 1'b0;
    flags_d = flags_q;
    halt_d  = 1'b0;
    code_d  = code_q;
    case (act_q)
      OpEnd: begin
        halt_d = 1'b1;
        code_d = StatEnd;
      end
      OpAdd, OpAddI: begin
        res = sum[31:0];
        wr  = 1'b1;
        flags_d[FlagC] = sum[DataWidth];
        flags_d[FlagV] = ~(opa[31] ^ opnd2[31]) & (opa[31] ^ res[31]);
      end
      OpSub, OpSubI: begin
        res = diff;
        wr  = 1'b1;
        flags_d[FlagC] = (opa >= opnd2);
        flags_d[FlagV] = (opa[31] ^ opnd2[31]) & (opa[31] ^ res[31]);
      end
      OpMul, OpMulI: begin
        res = prod;
        wr  = 1'b1;
      end
      OpDiv, OpDivI: begin
        if (div_zero) begin
          halt_d = 1'b1;
          code_d = StatDivZero;
        end else begin
          res = div_res;
          wr  = 1'b1;
        end
      end
      OpLoadReg, OpLoadAbs: begin
        res = dm_rdata;
        wr  = 1'b1;
      end
      OpMovZ: begin
        res = {24'd0, s1_q};
        wr  = 1'b1;
      end
      OpNot: begin
        res = ~opa;
        wr  = 1'b1;
      end
      OpMovS: begin
        res = imm_a;
        wr  = 1'b1;
      end
      OpStoreReg, OpStoreAbs: ;
      default: begin
        if (!is_br) begin
          halt_d = 1'b1;
          code_d = StatInvalid;
        end
      end
    endcase
    if (wr) begin
      flags_d[FlagZ] = (res == '0);
      flags_d[FlagN] = res[31];
    end
  end

  // Next program counter.
  assign pc_inc = pc_q + PC_WIDTH'(InsnBytes);
  assign pc_br  = pc_q + (PC_WIDTH'($signed(s2_q)) << 2);
  assign take   = is_br && cond_holds(act_q, flags_q);
  assign pc_d   = take ? pc_br : pc_inc;

  // Architectural state update at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      flags_q <= '0;
      stop_q  <= 1'b0;
      code_q  <= StatOk;
    end else if (cmd_i.commit && !stop_q) begin
      pc_q    <= pc_d;
      flags_q <= flags_d;
      stop_q  <= halt_d;
      code_q  <= code_d;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + ClrW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (stop_q) begin
        out_q.next_pc       <= 16'(pc_q);
        out_q.halted        <= 1'b1;
        out_q.status        <= code_q;
        out_q.zero_flag     <= flags_q[FlagZ];
        out_q.negative_flag <= flags_q[FlagN];
        out_q.carry_flag    <= flags_q[FlagC];
        out_q.overflow_flag <= flags_q[FlagV];
        out_q.reg_written   <= 1'b0;
        out_q.written_index <= '0;
        out_q.written_value <= '0;
      end else begin
        out_q.next_pc       <= 16'(pc_d);
        out_q.halted        <= halt_d;
        out_q.status        <= code_d;
        out_q.zero_flag     <= flags_d[FlagZ];
        out_q.negative_flag <= flags_d[FlagN];
        out_q.carry_flag    <= flags_d[FlagC];
        out_q.overflow_flag <= flags_d[FlagV];
        out_q.reg_written   <= wr;
        out_q.written_index <= wr ? 8'(widx) : 8'd0;
        out_q.written_value <= wr ? res : '0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Status toward the controller.
  assign need_div = !stop_q && ((is_div && !div_zero) ||
                    (!DataPow2 && (act_q inside {OpLoadReg, OpStoreReg})));
  assign sts_o.clear_done = cmd_i.clear && (clr_cnt_q == ClrW'(MaxDepth - 1));
  assign sts_o.need_div   = need_div;
  assign sts_o.need_load  = !stop_q && is_load;
  assign sts_o.div_busy   = div_busy || mod_busy_q;
  assign sts_o.out_free   = !out_valid_q || res_ready_i;

endmodule

### rtl/core/fape_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_ctrl
// Sequencer: memory clearing, instruction capture, execute, divide, load
// and commit of one instruction at a time.
// ----------------------------------------------------------------------------
module fape_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fape_pkg::fape_sts_t sts_i,
  output fape_pkg::fape_cmd_t cmd_o,
  output fape_pkg::fape_state_e state_o
);
  import fape_pkg::*;

  fape_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else if (sts_i.need_load) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = StLoad;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          if (sts_i.need_load) begin
            cmd_o.mem_rd = 1'b1;
            state_d      = StLoad;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StLoad, StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  assign state_o = state_q;

endmodule

### rtl/core/flag_alu_processor_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_alu_processor_execute
// Executes one instruction per transaction on a 32-bit register machine
// with NZCV flags and returns the updated PC, flags and register write.
// ----------------------------------------------------------------------------
// Sequence: capture, execute, commit. Loads first read data memory; divides first
//   run the divider (one quotient bit per cycle). Register-addressed loads and
//   stores first reduce the address when DATA_WORDS is not a power of two.
// Throughput: one instruction at a time; the next is accepted after commit.
// Reset: asynchronous; afterwards the register file and data memory are
//   zeroed by a sweep over max(REGISTER_COUNT, DATA_WORDS) addresses before the first accept.
module flag_alu_processor_execute #(
  parameter int unsigned REGISTER_COUNT = 256,
  parameter int unsigned DATA_WORDS     = 256,
  parameter int unsigned PC_WIDTH       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fape_inst_if.sink  inst_i,
  fape_res_if.source res_o
);
  import fape_pkg::*;

  fape_cmd_t   cmd;
  fape_sts_t   sts;
  fape_res_t   res;
  fape_state_e state;
  logic        res_valid;

  fape_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(inst_i.valid), .in_ready_o(inst_i.ready),
    .sts_i(sts), .cmd_o(cmd), .state_o(state)
  );

  fape_datapath #(
    .REGISTER_COUNT(REGISTER_COUNT), .DATA_WORDS(DATA_WORDS), .PC_WIDTH(PC_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i(inst_i.action), .dest_field_i(inst_i.dest_field),
    .src_a_field_i(inst_i.src_a_field), .src_b_field_i(inst_i.src_b_field),
    .res_ready_i(res_o.ready), .res_valid_o(res_valid), .res_o(res)
  );

  // Result channel.
  assign res_o.valid         = res_valid;
  assign res_o.next_pc       = res.next_pc;
  assign res_o.halted        = res.halted;
  assign res_o.status        = res.status;
  assign res_o.zero_flag     = res.zero_flag;
  assign res_o.negative_flag = res.negative_flag;
  assign res_o.carry_flag    = res.carry_flag;
  assign res_o.overflow_flag = res.overflow_flag;
  assign res_o.reg_written   = res.reg_written;
  assign res_o.written_index = res.written_index;
  assign res_o.written_value = res.written_value;

  // A commit never overwrites a result that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(res_valid && !res_o.ready))
    else $error("commit while result register occupied");

  // A halted machine reports a nonzero status and writes no register.
  a_halt_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_o.halted == (res_o.status != StatOk)))
    else $error("halt flag and status disagree");

  a_halt_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_o.halted) |-> !res_o.reg_written)
    else $error("register written by halting instruction");

  // No instruction is taken before memory clearing completes.
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == StClear) |-> !cmd.capture && !cmd.commit)
    else $error("instruction activity during memory clear");

endmodule

### tb/fape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fape_checker
// Watches the instruction and result channels, runs its own model of the
// register machine for every accepted instruction and compares each result
// transaction against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fape_checker
  import fape_pkg::*;
(
  input  logic        clk_i,
  fape_inst_if        inst_i,
  fape_res_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Architectural state of the machine as the checker sees it.
  logic [31:0] regs_q [ByteValues];
  logic [31:0] mem_q  [ByteValues];
  logic [15:0] pc_q;
  logic [3:0]  flags_q;
  logic        stopped_q;
  logic [1:0]  halt_code_q;

  fape_res_t expected_results[$];
  int unsigned mismatch_count;

  initial begin
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (mem_q[i]) mem_q[i] = '0;
    pc_q           = '0;
    flags_q        = '0;
    stopped_q      = 1'b0;
    halt_code_q    = StatOk;
    mismatch_count = 0;
  end

  assign fail_count_o = mismatch_count;
  assign pending_o    = expected_results.size();

  function automatic logic [31:0] sign_byte(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic void update_zn(logic [31:0] r);
    flags_q[FlagZ] = (r == '0);
    flags_q[FlagN] = r[31];
  endfunction

  function automatic logic [31:0] add_flags(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    update_zn(sum[31:0]);
    flags_q[FlagC] = sum[32];
    flags_q[FlagV] = (a[31] == b[31]) && (sum[31] != a[31]);
    return sum[31:0];
  endfunction

  function automatic logic [31:0] sub_flags(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    update_zn(diff);
    flags_q[FlagC] = (a >= b);
    flags_q[FlagV] = (a[31] != b[31]) && (diff[31] != a[31]);
    return diff;
  endfunction

  // Signed quotient truncated toward zero; the most negative value over -1 wraps.
  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic branch_taken(logic [7:0] op);
    logic z, n, c, v;
    z = flags_q[FlagZ];
    n = flags_q[FlagN];
    c = flags_q[FlagC];
    v = flags_q[FlagV];
    case (op)
      OpBrZ:   return z;
      OpBrNz:  return !z;
      OpBrC:   return c;
      OpBrNc:  return !c;
      OpBrN:   return n;
      OpBrNn:  return !n;
      OpBrV:   return v;
      OpBrNv:  return !v;
      OpBrHi:  return c && !z;
      OpBrLs:  return !c || z;
      OpBrGe:  return n == v;
      OpBrLt:  return n != v;
      OpBrGt:  return !z && (n == v);
      OpBrLe:  return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  // Executes one instruction on the checker's state and returns its result.
  function automatic fape_res_t execute_insn(logic [7:0] op, logic [7:0] d,
                                             logic [7:0] sa, logic [7:0] sb);
    fape_res_t   res;
    logic [15:0] here;
    logic [31:0] divisor, r, offset;
    logic        wr;
    res = '0;
    r   = '0;
    wr  = 1'b0;
    if (!stopped_q) begin
      here = pc_q;
      pc_q = here + 16'd4;
      case (op)
        OpEnd: begin
          stopped_q   = 1'b1;
          halt_code_q = StatEnd;
        end
        OpAdd:  begin r = add_flags(regs_q[sa], regs_q[sb]); wr = 1'b1; end
        OpSub:  begin r = sub_flags(regs_q[sa], regs_q[sb]); wr = 1'b1; end
        OpMul:  begin r = regs_q[sa] * regs_q[sb]; update_zn(r); wr = 1'b1; end
        OpDiv, OpDivI: begin
          divisor = (op == OpDiv) ? regs_q[sb] : sign_byte(sb);
          if (divisor == '0) begin
            stopped_q   = 1'b1;
            halt_code_q = StatDivZero;
          end else begin
            r  = quotient(regs_q[sa], divisor);
            update_zn(r);
            wr = 1'b1;
          end
        end
        OpLoadReg:  begin r = mem_q[regs_q[sb][7:0]]; update_zn(r); wr = 1'b1; end
        OpStoreReg: mem_q[regs_q[d][7:0]] = regs_q[sb];
        OpMovZ:     begin r = {24'd0, sa}; update_zn(r); wr = 1'b1; end
        OpNot:      begin r = ~regs_q[sa]; update_zn(r); wr = 1'b1; end
        OpAddI:     begin r = add_flags(regs_q[sa], sign_byte(sb)); wr = 1'b1; end
        OpSubI:     begin r = sub_flags(regs_q[sa], sign_byte(sb)); wr = 1'b1; end
        OpMulI:     begin r = regs_q[sa] * sign_byte(sb); update_zn(r); wr = 1'b1; end
        OpLoadAbs:  begin r = mem_q[sb]; update_zn(r); wr = 1'b1; end
        OpStoreAbs: mem_q[sb] = regs_q[sa];
        OpMovS:     begin r = sign_byte(sa); update_zn(r); wr = 1'b1; end
        default: begin
          if (op >= OpBrZ && op <= OpBrAl) begin
            if (branch_taken(op)) begin
              offset = sign_byte(sb) << 2;
              pc_q   = here + offset[15:0];
            end
          end else begin
            stopped_q   = 1'b1;
            halt_code_q = StatInvalid;
          end
        end
      endcase
      if (wr) begin
        regs_q[d]         = r;
        res.reg_written   = 1'b1;
        res.written_index = d;
        res.written_value = r;
      end
    end
    res.next_pc       = pc_q;
    res.halted        = stopped_q;
    res.status        = halt_code_q;
    res.zero_flag     = flags_q[FlagZ];
    res.negative_flag = flags_q[FlagN];
    res.carry_flag    = flags_q[FlagC];
    res.overflow_flag = flags_q[FlagV];
    return res;
  endfunction

  // Compare finished results first, then predict the newly accepted instruction.
  always @(posedge clk_i) begin
    fape_res_t got, want;
    if (res_i.valid && res_i.ready) begin
      got = '{next_pc: res_i.next_pc, halted: res_i.halted, status: res_i.status,
              zero_flag: res_i.zero_flag, negative_flag: res_i.negative_flag,
              carry_flag: res_i.carry_flag, overflow_flag: res_i.overflow_flag,
              reg_written: res_i.reg_written, written_index: res_i.written_index,
              written_value: res_i.written_value};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result transaction pc=%h", got.next_pc);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: result mismatch: exp pc=%h h=%b st=%0d znc v=%b%b%b%b ",
                      "wr=%b idx=%0d val=%h / got pc=%h h=%b st=%0d znc v=%b%b%b%b ",
                      "wr=%b idx=%0d val=%h"},
                     want.next_pc, want.halted, want.status, want.zero_flag,
                     want.negative_flag, want.carry_flag, want.overflow_flag,
                     want.reg_written, want.written_index, want.written_value,
                     got.next_pc, got.halted, got.status, got.zero_flag,
                     got.negative_flag, got.carry_flag, got.overflow_flag,
                     got.reg_written, got.written_index, got.written_value);
        end
      end
    end
    if (inst_i.valid && inst_i.ready)
      expected_results.push_back(execute_insn(inst_i.action, inst_i.dest_field,
                                              inst_i.src_a_field, inst_i.src_b_field));
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives instruction transactions into the execute block with random gaps
// and random result back-pressure: a directed program for the corner cases,
// random programs that keep the machine running, and a final halt.
// ----------------------------------------------------------------------------
module testbench;
  import fape_pkg::*;

  localparam int unsigned RandomInsns = 1500;
  localparam int unsigned IdleLimit   = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        burst_mode;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;

  fape_inst_if inst_ch ();
  fape_res_if  res_ch ();

  flag_alu_processor_execute dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inst_i (inst_ch),
    .res_o  (res_ch)
  );

  fape_checker checker_i (
    .clk_i        (clk_i),
    .inst_i       (inst_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Gap drawn per transaction; burst stretches use no gaps at all.
  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 13);
  endfunction

  // Mostly a small register window so values feed each other.
  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 15));
  endfunction

  // Sends one instruction transaction and waits for its acceptance.
  task automatic send_insn(logic [7:0] op, logic [7:0] d, logic [7:0] sa, logic [7:0] sb);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk_i);
    inst_ch.valid       = 1'b1;
    inst_ch.action      = op;
    inst_ch.dest_field  = d;
    inst_ch.src_a_field = sa;
    inst_ch.src_b_field = sb;
    do @(posedge clk_i); while (!inst_ch.ready);
    @(negedge clk_i);
    inst_ch.valid = 1'b0;
  endtask

  // One random instruction that never halts the machine.
  task automatic send_random_insn();
    logic [7:0] divisor_reg;
    logic [7:0] imm;
    case ($urandom_range(0, 9))
      0: send_insn(8'($urandom_range(OpAdd, OpMul)), pick_reg(), pick_reg(), pick_reg());
      1: send_insn(($urandom_range(0, 1) == 0) ? OpNot : OpLoadReg,
                   pick_reg(), pick_reg(), pick_reg());
      2: send_insn(($urandom_range(0, 1) == 0) ? OpStoreReg : OpStoreAbs,
                   pick_reg(), pick_reg(), 8'($urandom));
      3: send_insn(8'($urandom_range(OpAddI, OpMulI)), pick_reg(), pick_reg(), 8'($urandom));
      4: send_insn(($urandom_range(0, 1) == 0) ? OpMovZ : OpMovS,
                   pick_reg(), 8'($urandom), 8'($urandom));
      5: send_insn(OpLoadAbs, pick_reg(), 8'($urandom), 8'($urandom));
      6: begin
        // Register divide behind a nonzero divisor loaded just before.
        divisor_reg = pick_reg();
        imm         = 8'($urandom_range(1, 255));
        send_insn(OpMovS, divisor_reg, imm, 8'($urandom));
        send_insn(OpDiv, pick_reg(), pick_reg(), divisor_reg);
      end
      7: send_insn(OpDivI, pick_reg(), pick_reg(), 8'($urandom_range(1, 255)));
      default: send_insn(8'($urandom_range(OpBrZ, OpBrAl)), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endcase
  endtask

  // Result side: random stalls ahead of every result transaction.
  initial begin
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = draw_gap();
      repeat (stall) @(negedge clk_i);
      res_ch.ready = 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      @(negedge clk_i);
      res_ch.ready = 1'b0;
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((inst_ch.valid && inst_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned halt_kind;
    idle_cycles         = 0;
    burst_mode          = 1'b0;
    inst_ch.valid       = 1'b0;
    inst_ch.action      = OpEnd;
    inst_ch.dest_field  = '0;
    inst_ch.src_a_field = '0;
    inst_ch.src_b_field = '0;
    rst_ni              = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed program: build extreme values and walk the flag corners.
    send_insn(OpMovZ, 8'd1, 8'd255, 8'd0);
    send_insn(OpMovS, 8'd2, 8'h80, 8'd0);
    send_insn(OpNot, 8'd5, 8'd0, 8'd0);
    send_insn(OpMovZ, 8'd6, 8'd128, 8'd0);
    send_insn(OpMul, 8'd7, 8'd6, 8'd6);
    send_insn(OpMul, 8'd8, 8'd7, 8'd7);
    send_insn(OpMulI, 8'd9, 8'd8, 8'd8);          // most negative value
    send_insn(OpDivI, 8'd10, 8'd9, 8'hFF);        // wraps to itself
    send_insn(OpSubI, 8'd11, 8'd9, 8'd1);         // signed overflow
    send_insn(OpAddI, 8'd12, 8'd5, 8'd1);         // carry out, zero
    send_insn(OpAdd, 8'd13, 8'd9, 8'd9);
    send_insn(OpSub, 8'd14, 8'd2, 8'd1);
    send_insn(OpDiv, 8'd15, 8'd2, 8'd1);          // negative over positive
    send_insn(OpStoreAbs, 8'd0, 8'd9, 8'd255);
    send_insn(OpLoadAbs, 8'd255, 8'd0, 8'd255);
    send_insn(OpStoreReg, 8'd5, 8'd0, 8'd1);      // address taken modulo depth
    send_insn(OpLoadReg, 8'd3, 8'd0, 8'd5);
    send_insn(OpBrAl, 8'd0, 8'd0, 8'h80);         // backward wrap below zero
    send_insn(OpBrAl, 8'd0, 8'd0, 8'h7F);
    send_insn(OpBrZ, 8'd0, 8'd0, 8'h10);
    send_insn(OpBrNz, 8'd0, 8'd0, 8'h10);
    send_insn(OpBrLe, 8'd0, 8'd0, 8'hF0);
    send_insn(OpMovS, 8'd255, 8'h7F, 8'd0);

    // Random programs, alternating gapped and back-to-back stretches.
    for (int unsigned i = 0; i < RandomInsns; i++) begin
      if (i % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_random_insn();
    end
    burst_mode = 1'b0;

    // One halt per run, then a few instructions the stopped machine ignores.
    halt_kind = $urandom_range(0, 2);
    case (halt_kind)
      0: send_insn(OpEnd, 8'd0, 8'd0, 8'd0);
      1: send_insn(OpDivI, 8'd1, 8'd1, 8'd0);
      default: send_insn(8'($urandom_range(128, 255)), 8'd0, 8'd0, 8'd0);
    endcase
    repeat (4) send_insn(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

    // Drain, then allow for the longest operation latency.
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### flag_alu_processor_execute.f
rtl/core/fape_pkg.sv
rtl/core/fape_if.sv
rtl/core/fape_ram.sv
rtl/core/fape_div.sv
rtl/core/fape_datapath.sv
rtl/core/fape_ctrl.sv
rtl/core/flag_alu_processor_execute.sv
tb/fape_checker.sv
tb/testbench.sv
